FILE: src/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// shared types, constants and arithmetic helpers of the stereo feedback delay
// ----------------------------------------------------------------------------
package sfd_pkg;

    // store depth must be a power of two
    localparam int STORE_DEPTH = 131072;
    localparam int SAMPLE_BITS = 24;
    localparam int ADDR_BITS   = $clog2(STORE_DEPTH);

    localparam int DELAY_BITS  = 17;
    localparam int GAIN_BITS   = 16;
    localparam int GAIN_FRAC   = 15;
    localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int SCALED_BITS = SAMPLE_BITS + 2;
    localparam int SUM_BITS    = SAMPLE_BITS + 3;

    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 32;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_DELAY    = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_DRY      = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] CFG_WET      = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] CFG_FEEDBACK = CFG_IDX_BITS'(3);

    localparam logic [DELAY_BITS-1:0] RST_DELAY    = DELAY_BITS'(12000);
    localparam logic [GAIN_BITS-1:0]  RST_DRY      = GAIN_BITS'(32768);
    localparam logic [GAIN_BITS-1:0]  RST_WET      = GAIN_BITS'(16384);
    localparam logic [GAIN_BITS-1:0]  RST_FEEDBACK = GAIN_BITS'(16384);

    typedef logic [ADDR_BITS-1:0]          t_addr;
    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [GAIN_BITS-1:0]          t_gain;
    typedef logic signed [SCALED_BITS-1:0] t_scaled;
    typedef logic signed [SUM_BITS-1:0]    t_sum;

    typedef struct packed {
        t_sample left_in;
        t_sample right_in;
    } t_in_frame;

    typedef struct packed {
        t_sample left_out;
        t_sample right_out;
    } t_out_frame;

    // per-lane control from the sequencing logic
    typedef struct packed {
        logic  adv;
        t_addr rd_addr;
        logic  wr_en;
        t_addr wr_addr;
        logic  clr;
    } t_lane_ctrl;

    // delay modulo store depth
    function automatic t_addr delay_mod(input logic [DELAY_BITS-1:0] d);
        logic [DELAY_BITS+ADDR_BITS-1:0] w;
        w = {{ADDR_BITS{1'b0}}, d};
        return w[ADDR_BITS-1:0];
    endfunction

    // q1.15 gain times sample, fraction dropped toward minus infinity
    function automatic t_scaled gain_mul(input t_gain g, input t_sample s);
        logic signed [PROD_BITS-1:0] p;
        p = $signed({1'b0, g}) * s;
        p = p >>> GAIN_FRAC;
        return $signed(p[SCALED_BITS-1:0]);
    endfunction

    function automatic t_sample saturate(input t_sum v);
        logic [SUM_BITS-1:0] u;
        u = v;
        if ((&u[SUM_BITS-1:SAMPLE_BITS-1]) || !(|u[SUM_BITS-1:SAMPLE_BITS-1])) begin
            return $signed(u[SAMPLE_BITS-1:0]);
        end else if (u[SUM_BITS-1]) begin
            return $signed({1'b1, {(SAMPLE_BITS-1){1'b0}}});
        end else begin
            return $signed({1'b0, {(SAMPLE_BITS-1){1'b1}}});
        end
    endfunction

endpackage

FILE: src/stereo_feedback_delay_core.sv
// ----------------------------------------------------------------------------
// stereo_feedback_delay_core
// stereo echo: two delay lanes with shared write position, dry/wet mix and
// feedback, merged into one output frame
// ----------------------------------------------------------------------------
// pipeline: store read and sample, then gain products, then the output frame register
// throughput: one frame per cycle, held by output stalls and the clearing pass; a delay of
//   1 or 2 samples stalls the input until the frame writing the needed entry is stored
// reset: clears the control state, then a clearing pass zeroes both stores, one entry
//   per cycle through all 131072, with o_in_ready low; configuration is taken during it
// ----------------------------------------------------------------------------
module stereo_feedback_delay_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input frames
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  sfd_pkg::t_in_frame                  i_in_data,
    // output frames
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output sfd_pkg::t_out_frame                 o_out_data,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sfd_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [sfd_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    // configuration registers
    logic [sfd_pkg::DELAY_BITS-1:0] r_delay;
    sfd_pkg::t_gain                 r_dry;
    sfd_pkg::t_gain                 r_wet;
    sfd_pkg::t_gain                 r_fb;

    // sequencing state
    sfd_pkg::t_addr r_wp;
    logic           r_clr_busy;
    sfd_pkg::t_addr r_clr_addr;
    logic           r_v1;
    logic           r_v2;
    sfd_pkg::t_addr r_wr1;
    sfd_pkg::t_addr r_wr2;

    logic                adv;
    logic                hazard;
    logic                accept;
    sfd_pkg::t_addr      rd_addr;
    sfd_pkg::t_lane_ctrl lane_ctrl;
    sfd_pkg::t_sample    left_res;
    sfd_pkg::t_sample    right_res;

    assign o_cfg_ready = 1'b1;

    // register writes, values masked to register width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= sfd_pkg::RST_DELAY;
            r_dry   <= sfd_pkg::RST_DRY;
            r_wet   <= sfd_pkg::RST_WET;
            r_fb    <= sfd_pkg::RST_FEEDBACK;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sfd_pkg::CFG_DELAY:    r_delay <= i_cfg_data[sfd_pkg::DELAY_BITS-1:0];
                sfd_pkg::CFG_DRY:      r_dry   <= i_cfg_data[sfd_pkg::GAIN_BITS-1:0];
                sfd_pkg::CFG_WET:      r_wet   <= i_cfg_data[sfd_pkg::GAIN_BITS-1:0];
                sfd_pkg::CFG_FEEDBACK: r_fb    <= i_cfg_data[sfd_pkg::GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // read position trails the write position by the delay, wrapping naturally
    assign rd_addr = r_wp - sfd_pkg::delay_mod(r_delay);

    // pipeline moves when the output register is free or being drained
    assign adv = !o_out_valid || i_out_ready;

    // an in-flight frame that has not yet stored its entry blocks a read of it
    assign hazard = (r_v1 && (r_wr1 == rd_addr)) || (r_v2 && (r_wr2 == rd_addr));

    assign o_in_ready = !r_clr_busy && adv && !hazard;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == sfd_pkg::ADDR_BITS'(sfd_pkg::STORE_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (accept) begin
                r_wp <= r_wp + 1'b1;
            end
            if (adv) begin
                r_v1 <= accept;
                r_v2 <= r_v1;
            end
        end
    end

    // write addresses travel with the frames
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_wr1 <= r_wp;
            r_wr2 <= r_wr1;
        end
    end

    // shared lane control: clearing pass owns the write port while busy
    always_comb begin
        lane_ctrl.adv     = adv;
        lane_ctrl.rd_addr = rd_addr;
        lane_ctrl.clr     = r_clr_busy;
        lane_ctrl.wr_en   = r_clr_busy || (adv && r_v2);
        lane_ctrl.wr_addr = r_clr_busy ? r_clr_addr : r_wr2;
    end

    sfd_lane u_left (
        .i_clk      (i_clk),
        .i_ctrl     (lane_ctrl),
        .i_sample   (i_in_data.left_in),
        .i_dry_gain (r_dry),
        .i_wet_gain (r_wet),
        .i_fb_gain  (r_fb),
        .o_out      (left_res)
    );

    sfd_lane u_right (
        .i_clk      (i_clk),
        .i_ctrl     (lane_ctrl),
        .i_sample   (i_in_data.right_in),
        .i_dry_gain (r_dry),
        .i_wet_gain (r_wet),
        .i_fb_gain  (r_fb),
        .o_out      (right_res)
    );

    sfd_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (adv && r_v2),
        .i_left      (left_res),
        .i_right     (right_res),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // a new output only comes from a frame leaving the last stage
    a_out_from_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_v2))
        else $error("output valid without a frame in the last stage");

    // consecutive in-flight frames hold consecutive write positions
    a_wr_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2) |-> (r_wr1 == r_wr2 + 1'b1))
        else $error("in-flight write positions out of order");

    // write position steps by one per input transaction
    a_wp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_wp == $past(r_wp) + 1'b1))
        else $error("write position did not advance");

    // nothing reaches the output before the stores are cleared
    a_clear_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (!o_out_valid && !r_v1 && !r_v2))
        else $error("frame in flight during clearing pass");

endmodule

FILE: src/sfd_lane.sv
// ----------------------------------------------------------------------------
// sfd_lane
// one channel: delay store, gain products, mix and feedback saturation
// ----------------------------------------------------------------------------
module sfd_lane (
    input  logic                i_clk,
    input  sfd_pkg::t_lane_ctrl i_ctrl,
    input  sfd_pkg::t_sample    i_sample,
    input  sfd_pkg::t_gain      i_dry_gain,
    input  sfd_pkg::t_gain      i_wet_gain,
    input  sfd_pkg::t_gain      i_fb_gain,
    output sfd_pkg::t_sample    o_out
);

    sfd_pkg::t_sample r_store [sfd_pkg::STORE_DEPTH];

    sfd_pkg::t_sample r_rd_data;
    sfd_pkg::t_sample r_s1_in;
    sfd_pkg::t_sample r_s2_in;
    sfd_pkg::t_scaled r_dry_p;
    sfd_pkg::t_scaled r_wet_p;
    sfd_pkg::t_scaled r_fb_p;

    sfd_pkg::t_sample n_store_val;

    // registered read, old content on a same-edge write
    always_ff @(posedge i_clk) begin
        if (i_ctrl.adv) begin
            r_rd_data <= r_store[i_ctrl.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_store[i_ctrl.wr_addr] <= i_ctrl.clr ? '0 : n_store_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.adv) begin
            r_s1_in <= i_sample;
            r_s2_in <= r_s1_in;
            r_dry_p <= sfd_pkg::gain_mul(i_dry_gain, r_s1_in);
            r_wet_p <= sfd_pkg::gain_mul(i_wet_gain, r_rd_data);
            r_fb_p  <= sfd_pkg::gain_mul(i_fb_gain, r_rd_data);
        end
    end

    always_comb begin
        o_out = sfd_pkg::saturate({r_dry_p[sfd_pkg::SCALED_BITS-1], r_dry_p}
                                + {r_wet_p[sfd_pkg::SCALED_BITS-1], r_wet_p});
        n_store_val = sfd_pkg::saturate({{3{r_s2_in[sfd_pkg::SAMPLE_BITS-1]}}, r_s2_in}
                                      + {r_fb_p[sfd_pkg::SCALED_BITS-1], r_fb_p});
    end

endmodule

FILE: src/sfd_merge.sv
// ----------------------------------------------------------------------------
// sfd_merge
// joins the two lane results into one output frame register
// ----------------------------------------------------------------------------
module sfd_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  sfd_pkg::t_sample    i_left,
    input  sfd_pkg::t_sample    i_right,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output sfd_pkg::t_out_frame o_out_data
);

    logic                r_valid;
    sfd_pkg::t_out_frame r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data.left_out  <= i_left;
            r_data.right_out <= i_right;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

FILE: test/tb_stereo_feedback_delay_core.sv
// ----------------------------------------------------------------------------
// tb_stereo_feedback_delay_core
// self-checking bench for the stereo echo core: a scoreboard class mirrors
// both delay stores, the shared write position and the mix/feedback
// arithmetic, and compares every output transaction with its prediction while
// directed frames and random phases run under varied register settings and
// random handshake stalls
// ----------------------------------------------------------------------------
module tb_stereo_feedback_delay_core;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [sfd_pkg::DELAY_BITS-1:0]    t_delay;
    typedef logic [sfd_pkg::CFG_DATA_BITS-1:0] t_cfg_data;
    typedef logic [sfd_pkg::CFG_IDX_BITS-1:0]  t_cfg_idx;

    localparam sfd_pkg::t_sample SAMPLE_HI  = {1'b0, {(sfd_pkg::SAMPLE_BITS-1){1'b1}}};
    localparam sfd_pkg::t_sample SAMPLE_LO  = {1'b1, {(sfd_pkg::SAMPLE_BITS-1){1'b0}}};
    localparam sfd_pkg::t_gain   UNITY_GAIN = sfd_pkg::t_gain'(32768);
    localparam int               PHASES     = 9;
    localparam int               PHASE_LEN  = 100;

    // ------------------------------------------------------------------------
    // scoreboard: echo predictor plus queue of expected output frames
    // ------------------------------------------------------------------------
    class echo_scoreboard;
        sfd_pkg::t_sample    left_mem  [sfd_pkg::STORE_DEPTH];
        sfd_pkg::t_sample    right_mem [sfd_pkg::STORE_DEPTH];
        sfd_pkg::t_addr      wr_pos;
        t_delay              delay;
        sfd_pkg::t_gain      dry, wet, feedback;
        sfd_pkg::t_out_frame expected_frames [$];
        int                  errors;

        function new();
            foreach (left_mem[i]) begin
                left_mem[i]  = '0;
                right_mem[i] = '0;
            end
            wr_pos   = '0;
            delay    = sfd_pkg::RST_DELAY;
            dry      = sfd_pkg::RST_DRY;
            wet      = sfd_pkg::RST_WET;
            feedback = sfd_pkg::RST_FEEDBACK;
            errors   = 0;
        endfunction

        // register write, value masked to the register width
        function void apply_reg(t_cfg_idx idx, t_cfg_data data);
            case (idx)
                sfd_pkg::CFG_DELAY:    delay    = data[sfd_pkg::DELAY_BITS-1:0];
                sfd_pkg::CFG_DRY:      dry      = data[sfd_pkg::GAIN_BITS-1:0];
                sfd_pkg::CFG_WET:      wet      = data[sfd_pkg::GAIN_BITS-1:0];
                sfd_pkg::CFG_FEEDBACK: feedback = data[sfd_pkg::GAIN_BITS-1:0];
                default: ;
            endcase
        endfunction

        // q1.15 product, fraction dropped toward minus infinity
        function longint scale(sfd_pkg::t_gain g, sfd_pkg::t_sample s);
            return (longint'(g) * longint'(s)) >>> sfd_pkg::GAIN_FRAC;
        endfunction

        function sfd_pkg::t_sample clamp(longint v);
            if (v > longint'(SAMPLE_HI)) return SAMPLE_HI;
            if (v < longint'(SAMPLE_LO)) return SAMPLE_LO;
            return sfd_pkg::t_sample'(v);
        endfunction

        function void predict_echo(sfd_pkg::t_in_frame f);
            sfd_pkg::t_addr      rd;
            sfd_pkg::t_sample    dly_l, dly_r;
            sfd_pkg::t_out_frame e;
            // delay modulo store depth; delay zero reads the old entry
            rd    = wr_pos - sfd_pkg::t_addr'(delay);
            dly_l = left_mem[rd];
            dly_r = right_mem[rd];
            e.left_out  = clamp(scale(dry, f.left_in) + scale(wet, dly_l));
            e.right_out = clamp(scale(dry, f.right_in) + scale(wet, dly_r));
            left_mem[wr_pos]  = clamp(longint'(f.left_in) + scale(feedback, dly_l));
            right_mem[wr_pos] = clamp(longint'(f.right_in) + scale(feedback, dly_r));
            wr_pos = wr_pos + 1'b1;
            expected_frames.push_back(e);
        endfunction

        function void check_frame(sfd_pkg::t_out_frame got);
            sfd_pkg::t_out_frame e;
            if (expected_frames.size() == 0) begin
                errors++;
                $display("%0t unexpected output frame: expected none, actual %0d %0d",
                         $time, got.left_out, got.right_out);
                return;
            end
            e = expected_frames.pop_front();
            if (got.left_out !== e.left_out) begin
                errors++;
                $display("%0t left_out mismatch: expected %0d, actual %0d",
                         $time, e.left_out, got.left_out);
            end
            if (got.right_out !== e.right_out) begin
                errors++;
                $display("%0t right_out mismatch: expected %0d, actual %0d",
                         $time, e.right_out, got.right_out);
            end
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // dut and its signals
    // ------------------------------------------------------------------------
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    sfd_pkg::t_in_frame  i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    sfd_pkg::t_out_frame o_out_data;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    t_cfg_idx            i_cfg_index = '0;
    t_cfg_data           i_cfg_data  = '0;

    echo_scoreboard board = new();

    // idle percentages of sender and receiver, changed per phase
    int in_idle_pct  = 20;
    int out_idle_pct = 67;

    stereo_feedback_delay_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // run limit: clearing pass plus every frame at its slowest, many times over
    initial begin
        #10ms;
        $display("tb_stereo_feedback_delay_core: FAIL");
        $finish;
    end

    // receiver stalls at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    // monitors: every transaction is seen at the edge that completes it
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) board.apply_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) board.predict_echo(i_in_data);
            if (o_out_valid && i_out_ready) board.check_frame(o_out_data);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic sfd_pkg::t_in_frame frame(sfd_pkg::t_sample l, sfd_pkg::t_sample r);
        sfd_pkg::t_in_frame f;
        f.left_in  = l;
        f.right_in = r;
        return f;
    endfunction

    // full range mostly, with rails and values near zero mixed in
    function automatic sfd_pkg::t_sample pick_sample();
        case ($urandom_range(9))
            0:       return SAMPLE_HI;
            1:       return SAMPLE_LO;
            2:       return sfd_pkg::t_sample'(int'($urandom_range(1023)) - 512);
            default: return sfd_pkg::t_sample'($urandom);
        endcase
    endfunction

    // gains cover zero, unity, just below two and anything between
    function automatic sfd_pkg::t_gain pick_gain();
        case ($urandom_range(4))
            0:       return '0;
            1:       return UNITY_GAIN;
            2:       return '1;
            default: return sfd_pkg::t_gain'($urandom);
        endcase
    endfunction

    // valid stays up across back-to-back frames, dropped only while idling
    task automatic send_frame(sfd_pkg::t_in_frame f);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= f;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, t_cfg_data data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // all four registers with junk above their width, plus one write to an
    // index that does not exist
    task automatic program_regs(t_delay d, sfd_pkg::t_gain dr, sfd_pkg::t_gain wt,
                                sfd_pkg::t_gain fb);
        cfg_write(sfd_pkg::CFG_DELAY,
                  {(sfd_pkg::CFG_DATA_BITS-sfd_pkg::DELAY_BITS)'($urandom), d});
        cfg_write(sfd_pkg::CFG_DRY,
                  {(sfd_pkg::CFG_DATA_BITS-sfd_pkg::GAIN_BITS)'($urandom), dr});
        cfg_write(t_cfg_idx'($urandom_range(2**sfd_pkg::CFG_IDX_BITS-1,
                                            sfd_pkg::CFG_FEEDBACK+1)),
                  t_cfg_data'($urandom));
        cfg_write(sfd_pkg::CFG_WET,
                  {(sfd_pkg::CFG_DATA_BITS-sfd_pkg::GAIN_BITS)'($urandom), wt});
        cfg_write(sfd_pkg::CFG_FEEDBACK,
                  {(sfd_pkg::CFG_DATA_BITS-sfd_pkg::GAIN_BITS)'($urandom), fb});
        i_cfg_valid <= 1'b0;
    endtask

    // caller has just finished a transaction at this edge; valid goes low
    // and we wait until every predicted frame has come out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (board.pending() != 0);
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_delay         d;
        sfd_pkg::t_gain dr, wt, fb;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings first; the clearing pass holds these back
        send_frame(frame(SAMPLE_HI, SAMPLE_LO));
        send_frame(frame(SAMPLE_LO, SAMPLE_HI));
        send_frame(frame('0, '1));
        send_frame(frame(sfd_pkg::t_sample'(1), sfd_pkg::t_sample'(-2)));
        wait_drained();

        // shortest delay, every gain near two: feedback runs into the rails
        program_regs(t_delay'(1), '1, '1, '1);
        send_frame(frame(SAMPLE_HI, SAMPLE_HI));
        send_frame(frame(SAMPLE_LO, SAMPLE_LO));
        send_frame(frame(SAMPLE_HI, SAMPLE_LO));
        send_frame(frame(SAMPLE_LO, SAMPLE_HI));
        send_frame(frame('0, '0));
        send_frame(frame('1, sfd_pkg::t_sample'(1)));
        send_frame(frame(sfd_pkg::t_sample'(1), '1));
        wait_drained();

        // delay zero reads the entry before it is overwritten; zero gains
        program_regs('0, '0, '0, '0);
        send_frame(frame(SAMPLE_HI, SAMPLE_LO));
        send_frame(frame('1, SAMPLE_HI));
        send_frame(frame(SAMPLE_LO, '0));
        wait_drained();

        // longest delay reads entries still cleared by reset
        program_regs('1, UNITY_GAIN, '1, UNITY_GAIN);
        send_frame(frame(SAMPLE_LO, SAMPLE_LO));
        send_frame(frame(SAMPLE_HI, '1));
        send_frame(frame(sfd_pkg::t_sample'(12345), sfd_pkg::t_sample'(-54321)));
        wait_drained();

        // random phases: three with each idle profile
        for (int p = 0; p < PHASES; p++) begin
            if (p < 3) begin
                in_idle_pct  = 20;
                out_idle_pct = 67;
            end else if (p < 6) begin
                in_idle_pct  = 67;
                out_idle_pct = 20;
            end else begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            dr = pick_gain();
            wt = pick_gain();
            fb = pick_gain();
            case (p)
                0: begin
                    d  = t_delay'(2);
                    dr = sfd_pkg::RST_DRY;
                    wt = sfd_pkg::RST_WET;
                    fb = sfd_pkg::RST_FEEDBACK;
                end
                1: begin
                    d  = t_delay'($urandom_range(12, 3));
                    dr = '0;
                    wt = UNITY_GAIN;
                    fb = UNITY_GAIN;
                end
                2: d = t_delay'(1);
                3: d = t_delay'($urandom_range(64, 13));
                4: d = '1;
                5: d = '0;
                6: d = t_delay'($urandom_range(4, 1));
                7: d = t_delay'($urandom_range(200, 65));
                default: d = t_delay'($urandom_range(8, 2));
            endcase
            program_regs(d, dr, wt, fb);

            for (int n = 0; n < PHASE_LEN; n++) begin
                send_frame(frame(pick_sample(), pick_sample()));
                // hold the sender until the pipeline has fully emptied
                if (p == 4 && n == PHASE_LEN/2) wait_drained();
            end
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("tb_stereo_feedback_delay_core: PASS");
        end else begin
            $display("tb_stereo_feedback_delay_core: FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
src/sfd_pkg.sv
src/sfd_lane.sv
src/sfd_merge.sv
src/stereo_feedback_delay_core.sv
test/tb_stereo_feedback_delay_core.sv
